// ===== rtl/core/wht_pkg.sv =====
// Shared types and constants of the window hit test and cursor engine.
`default_nettype none

package wht_pkg;

   localparam int CLOSE_BOX    = 10;
   localparam int CLOSE_MARGIN = 4;

   localparam logic [14:0] RESET_SCREEN_WIDTH  = 15'd640;
   localparam logic [14:0] RESET_SCREEN_HEIGHT = 15'd480;
   localparam logic [7:0]  RESET_BORDER_WIDTH  = 8'd1;
   localparam logic [7:0]  RESET_TITLE_HEIGHT  = 8'd20;

   typedef enum logic [2:0] {
      CSR_SCREEN_WIDTH    = 3'd0,
      CSR_SCREEN_HEIGHT   = 3'd1,
      CSR_BORDER_WIDTH    = 3'd2,
      CSR_TITLE_HEIGHT    = 3'd3,
      CSR_MANAGER_PRESENT = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_NONE       = 3'd0,
      EV_CLOSE      = 3'd1,
      EV_DRAG_START = 3'd2,
      EV_CLICK      = 3'd3,
      EV_MOVED      = 3'd4,
      EV_FORWARD    = 3'd5,
      EV_WRITE_ACK  = 3'd6
   } event_type;

   typedef enum logic [1:0] {
      PATH_NONE  = 2'd0,
      PATH_PRESS = 2'd1,
      PATH_DRAG  = 2'd2,
      PATH_FWD   = 2'd3
   } path_type;

   typedef enum logic [1:0] {
      RD_SCAN  = 2'd0,
      RD_DRAG  = 2'd1,
      RD_FOCUS = 2'd2
   } rd_sel_type;

   typedef struct packed {
      logic               func;
      logic [3:0]         slot;
      logic signed [15:0] win_x;
      logic signed [15:0] win_y;
      logic [14:0]        win_width;
      logic [14:0]        win_height;
      logic [15:0]        win_ident;
      logic               live;
      logic               close_box;
      logic signed [15:0] move_dx;
      logic signed [15:0] move_dy;
      logic [2:0]         buttons;
   } req_type;

   typedef struct packed {
      logic [2:0]         event_res;
      logic [15:0]        target_ident;
      logic signed [15:0] local_x;
      logic signed [15:0] local_y;
      logic [14:0]        cursor_x;
      logic [14:0]        cursor_y;
      logic               cursor_moved;
      logic signed [15:0] new_x;
      logic signed [15:0] new_y;
      logic [2:0]         buttons_out;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        ident;
      logic               live;
      logic               close_box;
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic [14:0]        w;
      logic [14:0]        h;
   } entry_type;

   typedef struct packed {
      logic       capture;
      logic       table_write;
      logic       cursor_step;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       hit_eval;
      logic       drag_eval;
      logic       fwd_eval;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      path_type path;
      logic     hit;
      logic     scan_last;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/core/wht_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module wht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/wht_ctrl.sv =====
// Sequencer of the window hit test engine: walks each request through its steps.
`default_nettype none

module wht_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic                req_func,
   input  wire logic                rsp_stall,
   input  wht_pkg::status_type      status,
   output wht_pkg::cmd_type         cmd,
   output logic                     req_stall,
   output logic                     rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_WRITE, ST_CURSOR, ST_PATH, ST_SCAN_RD, ST_SCAN_CHK,
      ST_DRAG_RD, ST_DRAG_CHK, ST_FWD_RD, ST_FWD_CHK, ST_FIN
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = req_func ? ST_WRITE : ST_CURSOR;
            end
         end
         ST_WRITE: begin
            cmd.table_write = 1'b1;
            state_in = ST_FIN;
         end
         ST_CURSOR: begin
            cmd.cursor_step = 1'b1;
            state_in = ST_PATH;
         end
         ST_PATH: begin
            unique case (status.path)
               wht_pkg::PATH_PRESS: state_in = ST_SCAN_RD;
               wht_pkg::PATH_DRAG:  state_in = ST_DRAG_RD;
               wht_pkg::PATH_FWD:   state_in = ST_FWD_RD;
               default:             state_in = ST_FIN;
            endcase
         end
         ST_SCAN_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = wht_pkg::RD_SCAN;
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.hit_eval = 1'b1;
            state_in = (status.hit || status.scan_last) ? ST_FIN : ST_SCAN_RD;
         end
         ST_DRAG_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = wht_pkg::RD_DRAG;
            state_in = ST_DRAG_CHK;
         end
         ST_DRAG_CHK: begin
            cmd.drag_eval = 1'b1;
            state_in = ST_FIN;
         end
         ST_FWD_RD: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = wht_pkg::RD_FOCUS;
            state_in = ST_FWD_CHK;
         end
         ST_FWD_CHK: begin
            cmd.fwd_eval = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while a result waits");
   a_eval_after_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.hit_eval || cmd.drag_eval || cmd.fwd_eval) |-> $past(cmd.rd_en))
      else $error("table entry evaluated without a preceding read");
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.table_write, cmd.cursor_step, cmd.hit_eval, cmd.drag_eval,
                cmd.fwd_eval}))
      else $error("more than one datapath step commanded");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/wht_dp.sv =====
// Datapath: registers, window table, cursor arithmetic, hit test and result.
`default_nettype none

module wht_dp #(
   parameter int WINDOW_SLOTS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wht_pkg::req_type         req_data,
   input  wht_pkg::cmd_type         cmd,
   input  wire logic                csr_write,
   input  wire logic [2:0]          csr_index,
   input  wire logic [14:0]         csr_wdata,
   output wht_pkg::status_type      status,
   output wht_pkg::rsp_type         rsp_data
);

   localparam int IDX_W = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
   localparam int ENT_W = $bits(wht_pkg::entry_type);
   localparam logic [IDX_W-1:0] TOP_SLOT = IDX_W'(WINDOW_SLOTS - 1);

   logic [14:0] scr_w_ff, scr_h_ff;
   logic [7:0]  bw_ff, th_ff;
   logic        mgr_ff;

   wht_pkg::req_type  req_ff;
   wht_pkg::rsp_type  res_ff, res_in, out_ff;
   wht_pkg::path_type path_ff;

   logic [14:0]      cur_x_ff, cur_y_ff;
   logic [2:0]       prev_btn_ff;
   logic             drag_act_ff;
   logic [IDX_W-1:0] drag_slot_ff, focus_slot_ff, scan_ff;
   logic [31:0]      drag_off_ff;
   logic             focus_v_ff;
   logic [WINDOW_SLOTS-1:0] valid_ff;
   logic             rd_valid_ff;

   // Table port.
   logic             wr_en, slot_ok, move_wr;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   wht_pkg::entry_type wr_ent, ent, moved_ent;
   logic [ENT_W-1:0] ram_q;

   function automatic logic [14:0] clamp_axis(input logic signed [17:0] v,
                                              input logic [14:0] size);
      logic [14:0] r;
      if (v < 0 || size == '0) begin
         r = '0;
      end else if (v >= $signed({3'b000, size})) begin
         r = size - 15'd1;
      end else begin
         r = v[14:0];
      end
      return r;
   endfunction

   // Cursor update.
   logic signed [17:0] sum_x, sum_y;
   logic [14:0] new_cx, new_cy;
   logic        left, was_left;

   assign sum_x = $signed({3'b000, cur_x_ff})
                + $signed({{2{req_ff.move_dx[15]}}, req_ff.move_dx});
   assign sum_y = $signed({3'b000, cur_y_ff})
                + $signed({{2{req_ff.move_dy[15]}}, req_ff.move_dy});
   assign new_cx = clamp_axis(sum_x, scr_w_ff);
   assign new_cy = clamp_axis(sum_y, scr_h_ff);
   assign left = req_ff.buttons[0];
   assign was_left = prev_btn_ff[0];

   // Entry read back from the table; never-written slots read as empty.
   assign ent = rd_valid_ff ? wht_pkg::entry_type'(ram_q) : '0;

   // Hit test of the entry against the cursor.
   logic signed [18:0] mx, my, ex, ey, ew, eh, bw19, th19;
   logic signed [18:0] r_left, r_top, r_right, r_bottom, tdiff, half, bx, by;
   logic in_rect, in_close, in_title;
   logic signed [15:0] loc_x, loc_y;

   assign mx = $signed({4'b0000, cur_x_ff});
   assign my = $signed({4'b0000, cur_y_ff});
   assign ex = $signed({{3{ent.x[15]}}, ent.x});
   assign ey = $signed({{3{ent.y[15]}}, ent.y});
   assign ew = $signed({4'b0000, ent.w});
   assign eh = $signed({4'b0000, ent.h});
   assign bw19 = $signed({11'b0, bw_ff});
   assign th19 = $signed({11'b0, th_ff});
   assign r_left = ex - bw19;
   assign r_top = ey - th19 - bw19;
   assign r_right = ex + ew + bw19;
   assign r_bottom = ey + eh;
   // Title minus box height, halved with truncation toward zero.
   assign tdiff = th19 - $signed(19'(wht_pkg::CLOSE_BOX));
   assign half = (tdiff + $signed({18'b0, tdiff[18]})) >>> 1;
   assign bx = ex + ew - $signed(19'(wht_pkg::CLOSE_BOX + wht_pkg::CLOSE_MARGIN));
   assign by = r_top + half;
   assign in_rect = ent.live && (mx >= r_left) && (my >= r_top)
                 && (mx < r_right) && (my < r_bottom);
   assign in_close = ent.close_box && (mx >= bx) && (my >= by)
                  && (mx < bx + $signed(19'(wht_pkg::CLOSE_BOX)))
                  && (my < by + $signed(19'(wht_pkg::CLOSE_BOX)));
   assign in_title = (my < ey);
   assign loc_x = $signed({1'b0, cur_x_ff} - ent.x);
   assign loc_y = $signed({1'b0, cur_y_ff} - ent.y);

   // Drag arithmetic.
   logic signed [15:0] nx, ny_raw, ny, miny, mloc_x, mloc_y;
   logic               moved;

   assign nx = $signed({1'b0, cur_x_ff} - drag_off_ff[15:0]);
   assign ny_raw = $signed({1'b0, cur_y_ff} - drag_off_ff[31:16]);
   assign miny = $signed(16'({8'b0, th_ff} + {8'b0, bw_ff}));
   assign ny = (ny_raw < miny) ? miny : ny_raw;
   assign moved = ent.live && ((ent.x != nx) || (ent.y != ny));
   assign mloc_x = $signed({1'b0, cur_x_ff} - nx);
   assign mloc_y = $signed({1'b0, cur_y_ff} - ny);

   always_comb begin
      moved_ent = ent;
      moved_ent.x = nx;
      moved_ent.y = ny;
   end

   assign slot_ok = ({3'b000, req_ff.slot} < 7'(WINDOW_SLOTS));
   assign move_wr = cmd.drag_eval && moved;

   always_comb begin
      wr_ent.ident = req_ff.win_ident;
      wr_ent.live = req_ff.live;
      wr_ent.close_box = req_ff.close_box;
      wr_ent.x = req_ff.win_x;
      wr_ent.y = req_ff.win_y;
      wr_ent.w = req_ff.win_width;
      wr_ent.h = req_ff.win_height;
      if (move_wr) begin
         wr_ent = moved_ent;
      end
   end

   assign wr_en = (cmd.table_write && slot_ok) || move_wr;
   assign wr_addr = move_wr ? drag_slot_ff : IDX_W'(req_ff.slot);

   always_comb begin
      case (cmd.rd_sel)
         wht_pkg::RD_DRAG:  rd_addr = drag_slot_ff;
         wht_pkg::RD_FOCUS: rd_addr = focus_slot_ff;
         default:           rd_addr = scan_ff;
      endcase
   end

   wht_ram #(
      .WIDTH(ENT_W),
      .DEPTH(WINDOW_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ENT_W'(wr_ent)),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   assign status.path = path_ff;
   assign status.hit = in_rect;
   assign status.scan_last = (scan_ff == '0);
   assign rsp_data = out_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         scr_w_ff <= wht_pkg::RESET_SCREEN_WIDTH;
         scr_h_ff <= wht_pkg::RESET_SCREEN_HEIGHT;
         bw_ff <= wht_pkg::RESET_BORDER_WIDTH;
         th_ff <= wht_pkg::RESET_TITLE_HEIGHT;
         mgr_ff <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            wht_pkg::CSR_SCREEN_WIDTH:    scr_w_ff <= csr_wdata;
            wht_pkg::CSR_SCREEN_HEIGHT:   scr_h_ff <= csr_wdata;
            wht_pkg::CSR_BORDER_WIDTH:    bw_ff <= csr_wdata[7:0];
            wht_pkg::CSR_TITLE_HEIGHT:    th_ff <= csr_wdata[7:0];
            wht_pkg::CSR_MANAGER_PRESENT: mgr_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Next value of the result being built for the current request.
   always_comb begin
      res_in = res_ff;
      if (cmd.table_write) begin
         res_in = '0;
         res_in.cursor_x = cur_x_ff;
         res_in.cursor_y = cur_y_ff;
         if (slot_ok) begin
            res_in.event_res = wht_pkg::EV_WRITE_ACK;
            res_in.target_ident = req_ff.win_ident;
         end
      end
      if (cmd.cursor_step) begin
         res_in = '0;
         res_in.cursor_x = new_cx;
         res_in.cursor_y = new_cy;
         res_in.cursor_moved = (new_cx != cur_x_ff) || (new_cy != cur_y_ff);
      end
      if (cmd.hit_eval && in_rect) begin
         if (in_close) begin
            if (mgr_ff) begin
               res_in.event_res = wht_pkg::EV_CLOSE;
               res_in.target_ident = ent.ident;
               res_in.local_x = loc_x;
               res_in.local_y = loc_y;
            end
         end else begin
            res_in.target_ident = ent.ident;
            res_in.local_x = loc_x;
            res_in.local_y = loc_y;
            if (in_title) begin
               res_in.event_res = wht_pkg::EV_DRAG_START;
            end else begin
               res_in.event_res = wht_pkg::EV_CLICK;
               res_in.buttons_out = req_ff.buttons;
            end
         end
      end
      if (move_wr) begin
         res_in.event_res = wht_pkg::EV_MOVED;
         res_in.target_ident = ent.ident;
         res_in.local_x = mloc_x;
         res_in.local_y = mloc_y;
         res_in.new_x = nx;
         res_in.new_y = ny;
      end
      if (cmd.fwd_eval && ent.live) begin
         res_in.event_res = wht_pkg::EV_FORWARD;
         res_in.target_ident = ent.ident;
         res_in.local_x = loc_x;
         res_in.local_y = loc_y;
         res_in.buttons_out = req_ff.buttons;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.out_load) begin
         out_ff <= res_ff;
      end
      res_ff <= res_in;
      if (cmd.cursor_step) begin
         scan_ff <= TOP_SLOT;
      end
      if (cmd.hit_eval && !in_rect) begin
         scan_ff <= scan_ff - 1'b1;
      end
   end

   // Engine state with defined reset values.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
         prev_btn_ff <= '0;
         drag_act_ff <= 1'b0;
         drag_slot_ff <= '0;
         drag_off_ff <= '0;
         focus_v_ff <= 1'b0;
         focus_slot_ff <= '0;
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
         path_ff <= wht_pkg::PATH_NONE;
      end else begin
         if (cmd.rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (cmd.cursor_step) begin
            cur_x_ff <= new_cx;
            cur_y_ff <= new_cy;
            prev_btn_ff <= req_ff.buttons;
            if (!left) begin
               drag_act_ff <= 1'b0;
            end
            if (left && !was_left) begin
               path_ff <= wht_pkg::PATH_PRESS;
            end else if (left && drag_act_ff) begin
               path_ff <= wht_pkg::PATH_DRAG;
            end else if (left && focus_v_ff) begin
               path_ff <= wht_pkg::PATH_FWD;
            end else begin
               path_ff <= wht_pkg::PATH_NONE;
            end
         end
         if (cmd.hit_eval && in_rect && !in_close) begin
            focus_v_ff <= 1'b1;
            focus_slot_ff <= scan_ff;
            if (in_title) begin
               drag_act_ff <= 1'b1;
               drag_slot_ff <= scan_ff;
               drag_off_ff <= {loc_y, loc_x};
            end
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_drag_slot_valid: assert property (@(posedge clock) disable iff (reset)
      drag_act_ff |-> valid_ff[drag_slot_ff])
      else $error("drag refers to a slot never written");
   a_focus_slot_valid: assert property (@(posedge clock) disable iff (reset)
      focus_v_ff |-> valid_ff[focus_slot_ff])
      else $error("focus refers to a slot never written");
   a_cursor_moved: assert property (@(posedge clock) disable iff (reset)
      cmd.cursor_step |=> (res_ff.cursor_moved ==
                           (cur_x_ff != $past(cur_x_ff) || cur_y_ff != $past(cur_y_ff))))
      else $error("cursor moved flag disagrees with cursor registers");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/window_hit_test_cursor_engine.sv =====
// Top level of the window hit test and cursor engine.
//
// Requests arrive on the req_ channel (valid and stall); one result per request
// leaves on the rsp_ channel. A request with func set loads one slot of the
// window table; otherwise it is a mouse packet that moves the clamped cursor
// and may hit-test, drag or forward to the focused window.
// A table write passes through its write step to the result stage. A mouse packet
// steps the cursor, picks a path, and then goes straight on when nothing is tested,
// reads and checks one table entry for a drag or forward, or for a new left press
// scans the slots top to bottom until a hit or the last slot, each slot being one
// table read followed by one compare step.
// The next request is accepted once the current one has reached the result
// register, even while that result is still stalled by the receiver; the
// engine then waits with its next result until the register is free.
// The csr_ port writes the configuration registers and is always ready; the user
// makes writes only while the engine is idle, which the block does not enforce.
// Synchronous reset restores the register defaults, empties the window table,
// homes the cursor at the origin and drops drag and focus.
`default_nettype none

module window_hit_test_cursor_engine #(
   parameter int WINDOW_SLOTS = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wht_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output wht_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [14:0]       csr_wdata
);

   wht_pkg::cmd_type    cmd;
   wht_pkg::status_type status;

   // Registers accept a write in any cycle.
   assign csr_ready = 1'b1;

   wht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_data.func),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid)
   );

   wht_dp #(
      .WINDOW_SLOTS(WINDOW_SLOTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
